// ===== rtl/fts_pkg.sv =====
`default_nettype none

package fts_pkg;

    localparam int NumW = 21;
    localparam int DenW = 24;
    localparam int CntW = $clog2(NumW);
    localparam int DW   = 11;

    localparam logic [NumW-1:0] TachClock     = NumW'(1350000);
    localparam logic [DenW-1:0] SlowRpm       = DenW'(664);
    localparam logic [NumW-1:0] HalveThresh   = NumW'(192);
    localparam logic [7:0]      LimitDisabled = 8'd255;
    localparam logic [7:0]      LimitSlow     = 8'd254;
    localparam logic [7:0]      CountMax      = 8'd255;
    localparam logic [1:0]      CodeMax       = 2'd3;

    typedef enum logic [1:0] {
        OP_SET_LIMIT = 2'd0,
        OP_MEAS      = 2'd1,
        OP_LIMIT     = 2'd2,
        OP_LOAD      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_op         opcode;
        logic        channel;
        logic [23:0] speed_rpm;
        logic [7:0]  reg_byte;
    } t_in;

    typedef struct packed {
        logic [7:0]  limit_count;
        logic [1:0]  div_code;
        logic        div_changed;
        logic [20:0] rpm_out;
        logic        count_error;
    } t_out;

endpackage

`default_nettype wire

// ===== rtl/fan_tach_divider_select_top.sv =====
`default_nettype none

// Limit, count and load operations that need no division go from acceptance straight to
// the finish state; those that divide wait in the divider state first, and the result is
// registered from the finish state once the output is not stalled. One transaction at a
// time; division uses the 21-step restoring divider that yields one quotient bit per cycle.
// Reset (synchronous, active low) clears both divider codes to 0 and empties the output.
module fan_tach_divider_select_top (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire fts_pkg::t_in    i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output fts_pkg::t_out        o_out_data,
    input  wire logic            i_out_stall
);
    import fts_pkg::*;

    t_state          r_state, n_state;
    logic [1:0]      r_code [2];
    logic [1:0]      n_code [2];
    logic            r_ch, n_ch;
    t_op             r_op, n_op;
    logic [1:0]      r_old, n_old;
    t_out            r_res, n_res;
    t_out            r_out, n_out;
    logic            r_out_valid, n_out_valid;

    logic            div_start;
    logic [NumW-1:0] div_num;
    logic [DenW-1:0] div_den;
    logic            div_done;
    logic [NumW-1:0] div_quot;

    logic [1:0]      old_code;
    logic [1:0]      bumped;
    logic [1:0]      load_code;
    logic [DW-1:0]   d;
    logic [NumW-1:0] q;
    logic [1:0]      hcode;

    fts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_ch        = r_ch;
        n_op        = r_op;
        n_old       = r_old;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        div_start   = 1'b0;
        div_num     = TachClock;
        div_den     = i_in_data.speed_rpm;

        old_code  = r_code[i_in_data.channel];
        bumped    = (i_in_data.opcode == OP_MEAS && i_in_data.reg_byte == CountMax
                     && old_code != CodeMax) ? old_code + 2'd1 : old_code;
        load_code = i_in_data.channel ? i_in_data.reg_byte[7:6] : i_in_data.reg_byte[5:4];
        d         = {3'b000, i_in_data.reg_byte} << bumped;

        q     = div_quot;
        hcode = 2'd0;
        for (int i = 0; i < 3; i++) begin
            if (q > HalveThresh) begin
                q     = q >> 1;
                hcode = hcode + 2'd1;
            end
        end
        if (q == '0) begin
            q = NumW'(1);
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_ch             = i_in_data.channel;
                    n_op             = i_in_data.opcode;
                    n_old            = old_code;
                    n_res            = '0;
                    n_res.div_code   = old_code;
                    n_state          = ST_FINISH;
                    unique case (i_in_data.opcode)
                        OP_SET_LIMIT: begin
                            if (i_in_data.speed_rpm == '0) begin
                                n_res.limit_count = LimitDisabled;
                            end else if (i_in_data.speed_rpm < SlowRpm) begin
                                n_code[i_in_data.channel] = CodeMax;
                                n_res.limit_count         = LimitSlow;
                                n_res.div_code            = CodeMax;
                                n_res.div_changed         = (old_code != CodeMax);
                            end else begin
                                div_start = 1'b1;
                                n_state   = ST_DIV;
                            end
                        end
                        OP_MEAS, OP_LIMIT: begin
                            n_code[i_in_data.channel] = bumped;
                            n_res.div_code            = bumped;
                            n_res.div_changed         = (bumped != old_code);
                            if (i_in_data.reg_byte == '0) begin
                                n_res.count_error = 1'b1;
                            end else if (i_in_data.reg_byte != CountMax) begin
                                div_num   = TachClock + NumW'(d[DW-1:1]);
                                div_den   = DenW'(d);
                                div_start = 1'b1;
                                n_state   = ST_DIV;
                            end
                        end
                        OP_LOAD: begin
                            n_code[0]         = i_in_data.reg_byte[5:4];
                            n_code[1]         = i_in_data.reg_byte[7:6];
                            n_res.div_code    = load_code;
                            n_res.div_changed = (load_code != old_code);
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (r_op == OP_SET_LIMIT) begin
                        n_code[r_ch]      = hcode;
                        n_res.div_code    = hcode;
                        n_res.div_changed = (hcode != r_old);
                        n_res.limit_count = q[7:0];
                    end else begin
                        n_res.rpm_out = div_quot;
                    end
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
        end else begin
            r_state     <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code[0]   <= 2'd0;
            r_code[1]   <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_code      <= n_code;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch  <= n_ch;
        r_op  <= n_op;
        r_old <= n_old;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/fts_div.sv =====
`default_nettype none

module fts_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [fts_pkg::NumW-1:0]   i_num,
    input  wire logic [fts_pkg::DenW-1:0]   i_den,
    output logic                            o_done,
    output logic [fts_pkg::NumW-1:0]        o_quot
);
    import fts_pkg::*;

    logic            r_busy;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [NumW-1:0] r_quot;
    logic [DenW-1:0] r_rem;
    logic [DenW-1:0] r_den;

    logic [DenW:0]   trial;
    logic [DenW:0]   diff;
    logic            ge;

    always_comb begin
        trial = {r_rem, r_quot[NumW-1]};
        diff  = trial - {1'b0, r_den};
        ge    = ~diff[DenW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(NumW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, dividend shifts out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
            r_quot <= {r_quot[NumW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire
